FILE: rtl/lzow_pkg.sv
// Shared codes and types for the literal-origin walk block.
`timescale 1ns / 1ps

package lzow_pkg;

	// Stream word widths (fixed by the field layout)
	localparam int IN_TDATA_W  = 72;
	localparam int IN_TUSER_W  = 2;
	localparam int OUT_TDATA_W = 32;
	localparam int OUT_TUSER_W = 5;
	localparam int CFG_DATA_W  = 8;
	localparam int CFG_IDX_W   = 1;
	localparam int PORT_KEY_W  = 32;
	localparam int KF_W        = 3;

	// Input operation codes
	typedef enum logic [1:0] {
		OP_LOAD  = 2'd0,
		OP_QUERY = 2'd1,
		OP_CLEAR = 2'd2
	} op_t;

	// Token kinds, stored in the low two bits of the kind flags
	typedef enum logic [1:0] {
		KIND_LITERAL = 2'd0,
		KIND_MATCH   = 2'd1,
		KIND_OTHER   = 2'd2
	} kind_t;

	// Result status codes
	typedef enum logic [3:0] {
		STAT_PATH           = 4'd0,
		STAT_READY          = 4'd1,
		STAT_START_MISSING  = 4'd2,
		STAT_NO_SOURCE      = 4'd3,
		STAT_SOURCE_MISSING = 4'd4,
		STAT_BUDGET         = 4'd5,
		STAT_CYCLE          = 4'd6,
		STAT_LOADED         = 4'd7,
		STAT_FULL           = 4'd8,
		STAT_CLEARED        = 4'd9
	} status_t;

	// Configuration register indexes
	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_DEPTH_BUDGET = 1'b0,
		CFG_NODE_BUDGET  = 1'b1
	} cfg_idx_t;

	// Outcome of one table search
	typedef struct packed {
		logic done;
		logic hit;
	} srch_res_t;

endpackage

FILE: rtl/lzow_table.sv
// Token table memory with a sequential lowest-slot key search.
`timescale 1ns / 1ps

module lzow_table #(
	parameter int TABLE_ENTRIES = 32,
	parameter int KEY_BITS      = 32
) (
	input  logic                                clk,
	input  logic                                arst_n,
	// load write port
	input  logic                                wr_en,
	input  logic [$clog2(TABLE_ENTRIES)-1:0]    wr_addr,
	input  logic [KEY_BITS-1:0]                 wr_key,
	input  logic [KEY_BITS-1:0]                 wr_src,
	input  logic [lzow_pkg::KF_W-1:0]           wr_kf,
	// search control
	input  logic                                srch_start,
	input  logic [KEY_BITS-1:0]                 srch_key,
	input  logic [$clog2(TABLE_ENTRIES+1)-1:0]  entry_count,
	output lzow_pkg::srch_res_t                 srch,
	output logic [$clog2(TABLE_ENTRIES)-1:0]    hit_slot,
	output logic [KEY_BITS-1:0]                 hit_key,
	output logic [KEY_BITS-1:0]                 hit_src,
	output logic [lzow_pkg::KF_W-1:0]           hit_kf
);

	localparam int IDX_W = $clog2(TABLE_ENTRIES);
	localparam int CNT_W = $clog2(TABLE_ENTRIES + 1);

	logic [KEY_BITS-1:0]        key_mem [TABLE_ENTRIES];
	logic [KEY_BITS-1:0]        src_mem [TABLE_ENTRIES];
	logic [lzow_pkg::KF_W-1:0]  kf_mem  [TABLE_ENTRIES];

	logic                       busy_q;
	logic [CNT_W-1:0]           scan_idx_q;
	logic [KEY_BITS-1:0]        skey_q;
	logic                       rd_vld_s1;
	logic [IDX_W-1:0]           rd_idx_s1;
	logic [KEY_BITS-1:0]        rd_key_s1;
	logic [KEY_BITS-1:0]        rd_src_s1;
	logic [lzow_pkg::KF_W-1:0]  rd_kf_s1;

	logic hit;
	logic exhausted;
	logic issue;

	// Compare the entry that just came back; issue the next slot if no hit
	assign hit       = busy_q && rd_vld_s1 && (rd_key_s1 == skey_q);
	assign exhausted = busy_q && !hit && (scan_idx_q >= entry_count);
	assign issue     = busy_q && !hit && (scan_idx_q < entry_count);

	assign srch.done = hit || exhausted;
	assign srch.hit  = hit;
	assign hit_slot  = rd_idx_s1;
	assign hit_key   = rd_key_s1;
	assign hit_src   = rd_src_s1;
	assign hit_kf    = rd_kf_s1;

	// Search sequencing
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q     <= 1'b0;
			scan_idx_q <= '0;
			rd_vld_s1  <= 1'b0;
		end else if (srch_start) begin
			busy_q     <= 1'b1;
			scan_idx_q <= '0;
			rd_vld_s1  <= 1'b0;
		end else begin
			rd_vld_s1 <= issue;
			if (hit || exhausted) begin
				busy_q <= 1'b0;
			end
			if (issue) begin
				scan_idx_q <= CNT_W'(scan_idx_q + 1'b1);
			end
		end
	end

	// Hold the search key
	always_ff @(posedge clk) begin
		if (srch_start) begin
			skey_q <= srch_key;
		end
	end

	// Write a loaded entry
	always_ff @(posedge clk) begin
		if (wr_en) begin
			key_mem[wr_addr] <= wr_key;
			src_mem[wr_addr] <= wr_src;
			kf_mem[wr_addr]  <= wr_kf;
		end
	end

	// Registered read of the slot under scan
	always_ff @(posedge clk) begin
		if (issue) begin
			rd_idx_s1 <= scan_idx_q[IDX_W-1:0];
			rd_key_s1 <= key_mem[scan_idx_q[IDX_W-1:0]];
			rd_src_s1 <= src_mem[scan_idx_q[IDX_W-1:0]];
			rd_kf_s1  <= kf_mem[scan_idx_q[IDX_W-1:0]];
		end
	end

endmodule

FILE: rtl/lz_literal_origin_walk.sv
// A load or clear word is accepted whenever the walker is idle.
// A query walks source links; each hop scans the table memory from slot 0, one slot a cycle,
// stopping at the lowest slot that holds the key or after the last loaded entry.
// Worst case for a 32-entry table is 33 lookups, plus the closing word.
// Results leave through one output register; the walker stalls while it is full and not taken.
// Reset clears the entry count, the visited flags and sets both budgets to 32; no clearing pass.
`timescale 1ns / 1ps

module lz_literal_origin_walk #(
	parameter int TABLE_ENTRIES = 32,
	parameter int KEY_BITS      = 32
) (
	input  logic                                clk,
	input  logic                                arst_n,
	// tdata: token_key[31:0], token_kind[33:32], has_source[34], source_key[66:35], zero fill
	input  logic                                s_axis_tvalid,
	output logic                                s_axis_tready,
	input  logic [lzow_pkg::IN_TDATA_W-1:0]     s_axis_tdata,
	// tuser: op[1:0]
	input  logic [lzow_pkg::IN_TUSER_W-1:0]     s_axis_tuser,
	output logic                                m_axis_tvalid,
	input  logic                                m_axis_tready,
	// tdata: path_key[31:0]
	output logic [lzow_pkg::OUT_TDATA_W-1:0]    m_axis_tdata,
	// tuser: status[3:0], path_valid[4]
	output logic [lzow_pkg::OUT_TUSER_W-1:0]    m_axis_tuser,
	output logic                                m_axis_tlast,
	input  logic                                cfg_we,
	input  logic [lzow_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [lzow_pkg::CFG_DATA_W-1:0]     cfg_wdata
);

	localparam int IDX_W = $clog2(TABLE_ENTRIES);
	localparam int CNT_W = $clog2(TABLE_ENTRIES + 1);

	typedef enum logic [3:0] {
		S_IDLE  = 4'b0001,
		S_SCAN  = 4'b0010,
		S_VISIT = 4'b0100,
		S_CLOSE = 4'b1000
	} state_t;

	state_t                     state_q;
	logic [CNT_W-1:0]           count_q;
	logic [7:0]                 depth_q;
	logic [7:0]                 node_q;
	logic [TABLE_ENTRIES-1:0]   visited_q;
	logic [7:0]                 hops_q;
	logic [7:0]                 n_q;
	logic                       first_q;
	lzow_pkg::status_t          res_status_q;
	logic [IDX_W-1:0]           cur_slot_q;
	logic [KEY_BITS-1:0]        cur_key_q;
	logic [KEY_BITS-1:0]        cur_src_q;
	logic [lzow_pkg::KF_W-1:0]  cur_kf_q;

	logic                       out_valid_q;
	lzow_pkg::status_t          out_status_q;
	logic [lzow_pkg::PORT_KEY_W-1:0] out_key_q;
	logic                       out_pv_q;
	logic                       out_last_q;

	logic [1:0]                 in_op;
	logic [KEY_BITS-1:0]        in_key;
	logic [1:0]                 in_kind;
	logic                       in_hs;
	logic [KEY_BITS-1:0]        in_src;
	logic                       in_acc;
	logic                       full;
	logic                       budget_zero;

	logic                       out_free;
	logic                       out_load;
	lzow_pkg::status_t          out_status_d;
	logic [lzow_pkg::PORT_KEY_W-1:0] out_key_d;
	logic                       out_pv_d;

	logic                       wr_en;
	logic                       srch_start;
	logic [KEY_BITS-1:0]        srch_key;
	lzow_pkg::srch_res_t        srch;
	logic [IDX_W-1:0]           hit_slot;
	logic [KEY_BITS-1:0]        hit_key;
	logic [KEY_BITS-1:0]        hit_src;
	logic [lzow_pkg::KF_W-1:0]  hit_kf;

	state_t                     state_d;
	lzow_pkg::status_t          close_st;
	logic                       close_go;
	logic                       visit_emit;

	// Unpack the input word
	assign in_op   = s_axis_tuser[1:0];
	assign in_key  = KEY_BITS'(s_axis_tdata[31:0]);
	assign in_kind = s_axis_tdata[33:32];
	assign in_hs   = s_axis_tdata[34];
	assign in_src  = KEY_BITS'(s_axis_tdata[66:35]);

	assign s_axis_tready = (state_q == S_IDLE);
	assign in_acc        = s_axis_tvalid && s_axis_tready;
	assign full          = (count_q >= CNT_W'(TABLE_ENTRIES));
	assign budget_zero   = (depth_q == 8'd0) || (node_q == 8'd0);
	assign out_free      = !out_valid_q || m_axis_tready;

	assign wr_en      = in_acc && (in_op == lzow_pkg::OP_LOAD) && !full;
	assign srch_key   = (state_q == S_IDLE) ? in_key : cur_src_q;

	lzow_table #(
		.TABLE_ENTRIES(TABLE_ENTRIES),
		.KEY_BITS     (KEY_BITS)
	) u_table (
		.clk        (clk),
		.arst_n     (arst_n),
		.wr_en      (wr_en),
		.wr_addr    (count_q[IDX_W-1:0]),
		.wr_key     (in_key),
		.wr_src     (in_src),
		.wr_kf      ({in_hs, in_kind}),
		.srch_start (srch_start),
		.srch_key   (srch_key),
		.entry_count(count_q),
		.srch       (srch),
		.hit_slot   (hit_slot),
		.hit_key    (hit_key),
		.hit_src    (hit_src),
		.hit_kf     (hit_kf)
	);

	// Sequence the walk and pick the word to emit
	always_comb begin
		state_d      = state_q;
		close_st     = res_status_q;
		close_go     = 1'b0;
		visit_emit   = 1'b0;
		srch_start   = 1'b0;
		out_load     = 1'b0;
		out_status_d = res_status_q;
		out_key_d    = '0;
		out_pv_d     = 1'b0;
		unique case (state_q)
			S_IDLE: begin
				if (in_acc) begin
					close_go = 1'b1;
					case (in_op)
						lzow_pkg::OP_LOAD: begin
							close_st = full ? lzow_pkg::STAT_FULL : lzow_pkg::STAT_LOADED;
						end
						lzow_pkg::OP_CLEAR: begin
							close_st = lzow_pkg::STAT_CLEARED;
						end
						lzow_pkg::OP_QUERY: begin
							if (budget_zero) begin
								close_st = lzow_pkg::STAT_BUDGET;
							end else begin
								close_go   = 1'b0;
								srch_start = 1'b1;
								state_d    = S_SCAN;
							end
						end
						default: begin
							close_go = 1'b0;
						end
					endcase
					if (close_go) begin
						if (out_free) begin
							out_load     = 1'b1;
							out_status_d = close_st;
						end else begin
							state_d = S_CLOSE;
						end
					end
				end
			end
			S_SCAN: begin
				if (srch.done) begin
					if (srch.hit) begin
						state_d = S_VISIT;
					end else begin
						close_st = first_q ? lzow_pkg::STAT_START_MISSING
						                   : lzow_pkg::STAT_SOURCE_MISSING;
						state_d  = S_CLOSE;
					end
				end
			end
			S_VISIT: begin
				if (hops_q >= depth_q || n_q >= node_q) begin
					close_st = lzow_pkg::STAT_BUDGET;
					state_d  = S_CLOSE;
				end else if (visited_q[cur_slot_q]) begin
					close_st = lzow_pkg::STAT_CYCLE;
					state_d  = S_CLOSE;
				end else if (out_free) begin
					visit_emit   = 1'b1;
					out_load     = 1'b1;
					out_status_d = lzow_pkg::STAT_PATH;
					out_key_d    = lzow_pkg::PORT_KEY_W'(cur_key_q);
					out_pv_d     = 1'b1;
					if (cur_kf_q[1:0] == lzow_pkg::KIND_LITERAL) begin
						close_st = lzow_pkg::STAT_READY;
						state_d  = S_CLOSE;
					end else if (cur_kf_q[1:0] != lzow_pkg::KIND_MATCH || !cur_kf_q[2]) begin
						close_st = lzow_pkg::STAT_NO_SOURCE;
						state_d  = S_CLOSE;
					end else begin
						srch_start = 1'b1;
						state_d    = S_SCAN;
					end
				end
			end
			S_CLOSE: begin
				if (out_free) begin
					out_load     = 1'b1;
					out_status_d = res_status_q;
					state_d      = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	// Control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_IDLE;
			count_q   <= '0;
			visited_q <= '0;
			hops_q    <= '0;
			n_q       <= '0;
			first_q   <= 1'b0;
		end else begin
			state_q <= state_d;
			if (wr_en) begin
				count_q <= CNT_W'(count_q + 1'b1);
			end else if (in_acc && in_op == lzow_pkg::OP_CLEAR) begin
				count_q <= '0;
			end
			// start a query with fresh marks
			if (in_acc && in_op == lzow_pkg::OP_QUERY) begin
				visited_q <= '0;
				hops_q    <= '0;
				n_q       <= '0;
				first_q   <= 1'b1;
			end
			// mark the slot and advance to its source
			if (visit_emit) begin
				visited_q[cur_slot_q] <= 1'b1;
				n_q                   <= 8'(n_q + 1'b1);
				if (srch_start) begin
					hops_q  <= 8'(hops_q + 1'b1);
					first_q <= 1'b0;
				end
			end
		end
	end

	// Budget registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			depth_q <= 8'd32;
			node_q  <= 8'd32;
		end else if (cfg_we) begin
			unique case (cfg_index)
				lzow_pkg::CFG_DEPTH_BUDGET: depth_q <= cfg_wdata;
				lzow_pkg::CFG_NODE_BUDGET:  node_q  <= cfg_wdata;
				default: ;
			endcase
		end
	end

	// Hold the closing status and the entry found
	always_ff @(posedge clk) begin
		res_status_q <= close_st;
		if (state_q == S_SCAN && srch.hit) begin
			cur_slot_q <= hit_slot;
			cur_key_q  <= hit_key;
			cur_src_q  <= hit_src;
			cur_kf_q   <= hit_kf;
		end
	end

	// Output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			out_status_q <= out_status_d;
			out_key_q    <= out_key_d;
			out_pv_q     <= out_pv_d;
			out_last_q   <= !out_pv_d;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = out_key_q;
	assign m_axis_tuser  = {out_pv_q, out_status_q};
	assign m_axis_tlast  = out_last_q;

	// A search result only appears while the walker waits on it
	assert property (@(posedge clk) disable iff (!arst_n)
		srch.done |-> state_q == S_SCAN)
		else $error("table search finished outside the scan state");

	// A query with live budgets always enters the scan
	assert property (@(posedge clk) disable iff (!arst_n)
		(in_acc && in_op == lzow_pkg::OP_QUERY && !budget_zero) |=> state_q == S_SCAN)
		else $error("query did not start a table scan");

	// Emitting a path word marks its slot
	assert property (@(posedge clk) disable iff (!arst_n)
		(out_load && out_pv_d) |=> visited_q[cur_slot_q])
		else $error("visited slot not marked after path word");

	// A closing word leaves the walker idle
	assert property (@(posedge clk) disable iff (!arst_n)
		(out_load && !out_pv_d) |=> state_q == S_IDLE)
		else $error("walker not idle after closing word");

endmodule

FILE: dv/tb_top.sv
// Self-checking bench for the literal-origin walk: a token-table predictor scores every result word.
`timescale 1ns / 1ps

module tb_top;
	import lzow_pkg::*;

	localparam int  TABLE_ENTRIES = 32;
	localparam int  SETTLE_CYCLES = 64;
	// About 450 words, up to 33 results each, heavy stalls; several times over
	localparam int  LIMIT_CYCLES  = 3000000;
	localparam int  PHASES        = 3;
	localparam int  CHUNKS        = 4;
	localparam int  CHUNK_WORDS   = 28;

	// Codes the package leaves unnamed
	localparam logic [1:0] OP_UNUSED  = 2'd3;
	localparam logic [1:0] KIND_SPARE = 2'd3;

	typedef struct packed {
		status_t     status;
		logic [31:0] key;
		logic        valid;
		logic        last;
	} walk_word_t;

	typedef struct packed {
		logic [1:0]  op;
		logic [31:0] key;
		logic [1:0]  kind;
		logic        has_src;
		logic [31:0] src;
		logic        typed;
		status_t     status;
	} token_row_t;

	logic                   clk;
	logic                   arst_n;
	logic                   s_axis_tvalid;
	logic                   s_axis_tready;
	logic [IN_TDATA_W-1:0]  s_axis_tdata;
	logic [IN_TUSER_W-1:0]  s_axis_tuser;
	logic                   m_axis_tvalid;
	logic                   m_axis_tready;
	logic [OUT_TDATA_W-1:0] m_axis_tdata;
	logic [OUT_TUSER_W-1:0] m_axis_tuser;
	logic                   m_axis_tlast;
	logic                   cfg_we;
	logic [CFG_IDX_W-1:0]   cfg_index;
	logic [CFG_DATA_W-1:0]  cfg_wdata;

	// Predictor copy of the token table and budgets
	logic [31:0] trace_keys [TABLE_ENTRIES];
	logic [31:0] trace_srcs [TABLE_ENTRIES];
	logic [1:0]  trace_kinds [TABLE_ENTRIES];
	logic        trace_has_src [TABLE_ENTRIES];
	int          trace_count;
	logic [7:0]  depth_budget;
	logic [7:0]  path_limit;
	bit          table_quiet;

	walk_word_t  pending_walk_words [$];
	int          mismatches;
	int          cycle_count;
	int          snd_idle_pct;
	int          rcv_idle_pct;

	// Directed words; typed rows carry their closing status
	token_row_t directed_rows [0:20] = '{
		'{OP_QUERY,  32'h0000_0000, KIND_LITERAL, 1'b0, 32'h0,          1'b1, STAT_START_MISSING},
		'{OP_LOAD,   32'hFFFF_FFFF, KIND_LITERAL, 1'b0, 32'h0,          1'b1, STAT_LOADED},
		'{OP_QUERY,  32'hFFFF_FFFF, KIND_LITERAL, 1'b0, 32'h0,          1'b0, STAT_PATH},
		'{OP_LOAD,   32'h0000_0000, KIND_MATCH,   1'b1, 32'hFFFF_FFFF,  1'b1, STAT_LOADED},
		'{OP_QUERY,  32'h0000_0000, KIND_LITERAL, 1'b0, 32'h0,          1'b0, STAT_PATH},
		'{OP_LOAD,   32'h0000_0005, KIND_MATCH,   1'b0, 32'h0,          1'b1, STAT_LOADED},
		'{OP_QUERY,  32'h0000_0005, KIND_LITERAL, 1'b0, 32'h0,          1'b0, STAT_PATH},
		'{OP_LOAD,   32'h0000_0006, KIND_OTHER,   1'b1, 32'h0,          1'b1, STAT_LOADED},
		'{OP_QUERY,  32'h0000_0006, KIND_LITERAL, 1'b0, 32'h0,          1'b0, STAT_PATH},
		'{OP_LOAD,   32'h0000_0007, KIND_SPARE,   1'b1, 32'h0,          1'b1, STAT_LOADED},
		'{OP_QUERY,  32'h0000_0007, KIND_LITERAL, 1'b0, 32'h0,          1'b0, STAT_PATH},
		'{OP_LOAD,   32'h0000_0008, KIND_MATCH,   1'b1, 32'h1234_5678,  1'b1, STAT_LOADED},
		'{OP_QUERY,  32'h0000_0008, KIND_LITERAL, 1'b0, 32'h0,          1'b0, STAT_PATH},
		'{OP_LOAD,   32'h0000_0009, KIND_MATCH,   1'b1, 32'h0000_000A,  1'b1, STAT_LOADED},
		'{OP_LOAD,   32'h0000_000A, KIND_MATCH,   1'b1, 32'h0000_0009,  1'b1, STAT_LOADED},
		'{OP_QUERY,  32'h0000_0009, KIND_LITERAL, 1'b0, 32'h0,          1'b0, STAT_PATH},
		'{OP_LOAD,   32'h0000_0000, KIND_OTHER,   1'b0, 32'h0,          1'b1, STAT_LOADED},
		'{OP_QUERY,  32'h0000_0000, KIND_LITERAL, 1'b0, 32'h0,          1'b0, STAT_PATH},
		'{OP_UNUSED, 32'hFFFF_FFFF, KIND_SPARE,   1'b1, 32'hFFFF_FFFF,  1'b0, STAT_PATH},
		'{OP_CLEAR,  32'h0000_0000, KIND_LITERAL, 1'b0, 32'h0,          1'b1, STAT_CLEARED},
		'{OP_QUERY,  32'hFFFF_FFFF, KIND_LITERAL, 1'b0, 32'h0,          1'b1, STAT_START_MISSING}
	};

	lz_literal_origin_walk #(
		.TABLE_ENTRIES(TABLE_ENTRIES),
		.KEY_BITS     (32)
	) u_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata (s_axis_tdata),
		.s_axis_tuser (s_axis_tuser),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata (m_axis_tdata),
		.m_axis_tuser (m_axis_tuser),
		.m_axis_tlast (m_axis_tlast),
		.cfg_we       (cfg_we),
		.cfg_index    (cfg_index),
		.cfg_wdata    (cfg_wdata)
	);

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	// Queue one expected word unless a typed row already supplied it
	task automatic note_word(input status_t st, input logic [31:0] key, input logic valid,
			input logic last);
		walk_word_t w;
		w.status = st;
		w.key    = key;
		w.valid  = valid;
		w.last   = last;
		if (!table_quiet)
			pending_walk_words = {pending_walk_words, w};
	endtask

	// Lowest slot holding the key, or -1
	function automatic int find_slot(input logic [31:0] key);
		for (int i = 0; i < trace_count; i++)
			if (trace_keys[i] == key)
				return i;
		return -1;
	endfunction

	// Apply one accepted word to the table copy and queue its results
	task automatic predict_token_op(input logic [1:0] op, input logic [31:0] key,
			input logic [1:0] kind, input logic has_src, input logic [31:0] src);
		int                     slot;
		int                     n;
		int                     hops;
		bit                     done;
		logic [TABLE_ENTRIES-1:0] seen;
		if (op == OP_LOAD) begin
			if (trace_count >= TABLE_ENTRIES) begin
				note_word(STAT_FULL, '0, 1'b0, 1'b1);
			end else begin
				trace_keys[trace_count]    = key;
				trace_srcs[trace_count]    = src;
				trace_kinds[trace_count]   = kind;
				trace_has_src[trace_count] = has_src;
				trace_count++;
				note_word(STAT_LOADED, '0, 1'b0, 1'b1);
			end
		end else if (op == OP_CLEAR) begin
			trace_count = 0;
			note_word(STAT_CLEARED, '0, 1'b0, 1'b1);
		end else if (op == OP_QUERY) begin
			if (depth_budget == 0 || path_limit == 0) begin
				note_word(STAT_BUDGET, '0, 1'b0, 1'b1);
			end else begin
				slot = find_slot(key);
				if (slot < 0) begin
					note_word(STAT_START_MISSING, '0, 1'b0, 1'b1);
				end else begin
					seen = '0;
					n    = 0;
					hops = 0;
					done = 1'b0;
					// Follow source links until a closing condition
					while (!done) begin
						done = 1'b1;
						if (hops >= depth_budget || n >= path_limit) begin
							note_word(STAT_BUDGET, '0, 1'b0, 1'b1);
						end else if (seen[slot]) begin
							note_word(STAT_CYCLE, '0, 1'b0, 1'b1);
						end else begin
							seen[slot] = 1'b1;
							note_word(STAT_PATH, trace_keys[slot], 1'b1, 1'b0);
							n++;
							if (trace_kinds[slot] == KIND_LITERAL) begin
								note_word(STAT_READY, '0, 1'b0, 1'b1);
							end else if (trace_kinds[slot] != KIND_MATCH || !trace_has_src[slot]) begin
								note_word(STAT_NO_SOURCE, '0, 1'b0, 1'b1);
							end else begin
								slot = find_slot(trace_srcs[slot]);
								if (slot < 0) begin
									note_word(STAT_SOURCE_MISSING, '0, 1'b0, 1'b1);
								end else begin
									hops++;
									done = 1'b0;
								end
							end
						end
					end
				end
			end
		end
	endtask

	// Offer one word from a falling edge, hold until taken, return at the next falling edge
	task automatic send_word(input logic [1:0] op, input logic [31:0] key, input logic [1:0] kind,
			input logic has_src, input logic [31:0] src, input logic typed, input status_t st);
		while ($urandom_range(0, 99) < snd_idle_pct) begin
			s_axis_tvalid = 1'b0;
			@(negedge clk);
		end
		s_axis_tvalid = 1'b1;
		s_axis_tdata  = {5'b0, src, has_src, kind, key};
		s_axis_tuser  = op;
		do @(posedge clk); while (!s_axis_tready);
		if (typed) begin
			note_word(st, '0, 1'b0, 1'b1);
			table_quiet = 1'b1;
		end
		predict_token_op(op, key, kind, has_src, src);
		table_quiet = 1'b0;
		@(negedge clk);
	endtask

	// Drop valid and wait for every pending word, then for the walker to settle
	task automatic drain_results;
		s_axis_tvalid = 1'b0;
		while (pending_walk_words.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
		@(negedge clk);
	endtask

	// Write both budgets while the block is idle
	task automatic write_budgets(input logic [7:0] depth, input logic [7:0] nodes);
		drain_results();
		cfg_we    = 1'b1;
		cfg_index = CFG_DEPTH_BUDGET;
		cfg_wdata = depth;
		@(negedge clk);
		cfg_index = CFG_NODE_BUDGET;
		cfg_wdata = nodes;
		@(negedge clk);
		cfg_we       = 1'b0;
		depth_budget = depth;
		path_limit   = nodes;
	endtask

	// One table session: mostly a clean build then queries, sometimes noise
	task automatic run_session(inout int sent);
		logic [31:0] keys [0:33];
		logic [31:0] src;
		logic [1:0]  kind;
		logic        has_src;
		logic [1:0]  op;
		int          n;
		int          r;
		int          idx;
		bit          chain;
		bit          reversed;
		if ($urandom_range(0, 9) < 2) begin
			// Noise: any op, any field values
			repeat ($urandom_range(1, 4)) begin
				op = 2'($urandom_range(0, 3));
				send_word(op, $urandom, 2'($urandom_range(0, 3)), 1'($urandom_range(0, 1)),
					$urandom, 1'b0, STAT_PATH);
				if (op != OP_UNUSED)
					sent++;
			end
		end else begin
			r = $urandom_range(0, 9);
			if (r < 7)
				n = $urandom_range(1, 8);
			else if (r < 9)
				n = $urandom_range(9, 20);
			else
				n = $urandom_range(32, 34);
			for (int i = 0; i < n; i++)
				keys[i] = (i > 0 && $urandom_range(0, 4) == 0) ?
					keys[$urandom_range(0, i - 1)] : $urandom;
			// Most sessions start from an empty table; the rest pile onto what is there
			if ($urandom_range(0, 4) != 0) begin
				send_word(OP_CLEAR, $urandom, 2'($urandom_range(0, 3)), 1'($urandom_range(0, 1)),
					$urandom, 1'b0, STAT_PATH);
				sent++;
			end
			chain    = 1'($urandom_range(0, 1));
			reversed = 1'($urandom_range(0, 1));
			for (int j = 0; j < n; j++) begin
				idx = reversed ? n - 1 - j : j;
				if (chain) begin
					kind    = KIND_MATCH;
					has_src = 1'b1;
					if (idx < n - 1) begin
						src = keys[idx + 1];
					end else begin
						r   = $urandom_range(0, 9);
						src = (r < 3) ? keys[0] : $urandom;
						if (r >= 4)
							kind = KIND_LITERAL;
					end
				end else begin
					r = $urandom_range(0, 9);
					if (r < 2)
						kind = KIND_LITERAL;
					else if (r < 8)
						kind = KIND_MATCH;
					else if (r < 9)
						kind = KIND_OTHER;
					else
						kind = KIND_SPARE;
					has_src = ($urandom_range(0, 5) != 0);
					src     = ($urandom_range(0, 4) == 0) ? $urandom : keys[$urandom_range(0, n - 1)];
				end
				send_word(OP_LOAD, keys[idx], kind, has_src, src, 1'b0, STAT_PATH);
				sent++;
			end
			// Walk from loaded keys, now and then from a stray one
			repeat ($urandom_range(1, 4)) begin
				send_word(OP_QUERY,
					($urandom_range(0, 5) == 0) ? $urandom : keys[$urandom_range(0, n - 1)],
					2'($urandom_range(0, 3)), 1'($urandom_range(0, 1)), $urandom, 1'b0,
					STAT_PATH);
				sent++;
			end
		end
	endtask

	// Randomize receiver stalls
	initial begin
		m_axis_tready = 1'b0;
		forever begin
			@(negedge clk);
			m_axis_tready = ($urandom_range(0, 99) >= rcv_idle_pct);
		end
	end

	// Score each taken result word against the oldest expectation
	always @(posedge clk) begin
		walk_word_t exp_w;
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			if (pending_walk_words.size() == 0) begin
				$error("unexpected result word: status %0d path_key %h path_valid %0d last %0d",
					m_axis_tuser[3:0], m_axis_tdata, m_axis_tuser[4], m_axis_tlast);
				mismatches++;
			end else begin
				exp_w = pending_walk_words.pop_front();
				if (m_axis_tuser[3:0] !== exp_w.status) begin
					$error("status: expected %0d, actual %0d", exp_w.status, m_axis_tuser[3:0]);
					mismatches++;
				end
				if (m_axis_tdata !== exp_w.key) begin
					$error("path_key: expected %h, actual %h", exp_w.key, m_axis_tdata);
					mismatches++;
				end
				if (m_axis_tuser[4] !== exp_w.valid) begin
					$error("path_valid: expected %0d, actual %0d", exp_w.valid, m_axis_tuser[4]);
					mismatches++;
				end
				if (m_axis_tlast !== exp_w.last) begin
					$error("last: expected %0d, actual %0d", exp_w.last, m_axis_tlast);
					mismatches++;
				end
			end
		end
	end

	// Bound the run
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count >= LIMIT_CYCLES) begin
			$display("Mismatches found");
			$finish;
		end
	end

	initial begin
		logic [7:0] depth_set [0:11];
		logic [7:0] node_set  [0:11];
		int         sent;
		int         setting;
		depth_set = '{8'd255, 8'd0,  8'd1,   8'd255, 8'd32, 8'd2, 8'd255, 8'd0, 8'd4,   8'd255,
			8'd1, 8'd32};
		node_set  = '{8'd255, 8'd32, 8'd255, 8'd1,   8'd0,  8'd3, 8'd255, 8'd0, 8'd255, 8'd8,
			8'd1, 8'd32};
		arst_n        = 1'b0;
		s_axis_tvalid = 1'b0;
		s_axis_tdata  = '0;
		s_axis_tuser  = '0;
		cfg_we        = 1'b0;
		cfg_index     = CFG_DEPTH_BUDGET;
		cfg_wdata     = '0;
		trace_count   = 0;
		depth_budget  = 8'd32;
		path_limit    = 8'd32;
		table_quiet   = 1'b0;
		mismatches    = 0;
		cycle_count   = 0;
		snd_idle_pct  = 33;
		rcv_idle_pct  = 76;
		setting       = 0;

		// Hold reset, release on a falling edge
		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// Directed words at reset budgets
		foreach (directed_rows[i])
			send_word(directed_rows[i].op, directed_rows[i].key, directed_rows[i].kind,
				directed_rows[i].has_src, directed_rows[i].src, directed_rows[i].typed,
				directed_rows[i].status);

		// Random sessions across idle phases and budget settings
		for (int p = 0; p < PHASES; p++) begin
			if (p == 0) begin
				snd_idle_pct = 33;
				rcv_idle_pct = 76;
			end else if (p == 1) begin
				snd_idle_pct = 76;
				rcv_idle_pct = 33;
			end else begin
				snd_idle_pct = 0;
				rcv_idle_pct = 0;
			end
			for (int c = 0; c < CHUNKS; c++) begin
				write_budgets(depth_set[setting], node_set[setting]);
				setting++;
				sent = 0;
				while (sent < CHUNK_WORDS)
					run_session(sent);
			end
		end

		drain_results();
		if (mismatches == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end

endmodule
